// File: src/tpg_pkg.sv
// Shared types and constants for the trapezoid profile generator.
`timescale 1ns / 1ps

package tpg_pkg;

   localparam int VAL_W = 31;
   localparam int TIME_W = 32;
   localparam int PROD_W = 2 * VAL_W;
   localparam int FRAC_W = 16;

   localparam logic [1:0] PH_OUT  = 2'd0;
   localparam logic [1:0] PH_RISE = 2'd1;
   localparam logic [1:0] PH_FLAT = 2'd2;
   localparam logic [1:0] PH_FALL = 2'd3;

   localparam logic [1:0] REG_RISE_RATE      = 2'd0;
   localparam logic [1:0] REG_FALL_RATE      = 2'd1;
   localparam logic [1:0] REG_PLATEAU_LEVEL  = 2'd2;
   localparam logic [1:0] REG_TOTAL_DURATION = 2'd3;

   // Phase boundaries derived from the configuration.
   typedef struct packed {
      logic [VAL_W-1:0] rise_end;
      logic [VAL_W-1:0] flat_end;
   } tpg_thresh_type;

   // One classified time point waiting for its ramp multiply.
   typedef struct packed {
      logic [VAL_W-1:0] ramp_time;
      logic [VAL_W-1:0] rate;
      logic [1:0]       phase;
   } tpg_item_type;

endpackage

// File: src/tpg_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tpg_divider
   import tpg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [31:0]       divisor,
   output logic              done,
   output logic [PROD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(PROD_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [31:0]       dvs_ff, dvs_in;
   logic [32:0]       trial;
   logic              take;

   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign take  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = take ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         quo_in = {quo_ff[PROD_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/tpg_setup.sv
// Sequencer that derives the phase boundaries from the configuration registers.
`timescale 1ns / 1ps

module tpg_setup
   import tpg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic [VAL_W-1:0] up_rate,
   input  logic [VAL_W-1:0] dn_rate,
   input  logic [VAL_W-1:0] plateau,
   input  logic [VAL_W-1:0] duration,
   output logic             busy,
   output tpg_thresh_type   thresh
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_START  = 6'b000010,
      ST_DIV_UP = 6'b000100,
      ST_DIV_DN = 6'b001000,
      ST_DIV_PK = 6'b010000,
      ST_FINISH = 6'b100000
   } tpg_setup_state_type;

   tpg_setup_state_type state_ff, state_in;
   logic [PROD_W-1:0]   peak_num_ff, peak_num_in;
   logic [PROD_W-1:0]   t_up_ff, t_up_in;
   logic [PROD_W-1:0]   t_dn_ff, t_dn_in;
   logic [PROD_W-1:0]   t_pk_ff, t_pk_in;
   tpg_thresh_type      thresh_ff, thresh_in;
   logic                div_start, div_done;
   logic [PROD_W-1:0]   div_num, div_q, plateau_scaled;
   logic [31:0]         div_den;
   logic [PROD_W:0]     ramp_sum;
   logic                triangle;

   assign plateau_scaled = PROD_W'({plateau, {FRAC_W{1'b0}}});
   assign ramp_sum = {1'b0, t_up_ff} + {1'b0, t_dn_ff};
   assign triangle = ramp_sum > (PROD_W + 1)'(duration);

   always_comb begin
      state_in    = state_ff;
      peak_num_in = peak_num_ff;
      t_up_in     = t_up_ff;
      t_dn_in     = t_dn_ff;
      t_pk_in     = t_pk_ff;
      thresh_in   = thresh_ff;
      div_start   = 1'b0;
      div_num     = plateau_scaled;
      div_den     = {1'b0, up_rate};
      unique case (state_ff)
         ST_IDLE: ;
         ST_START: begin
            peak_num_in = PROD_W'(duration) * PROD_W'(dn_rate);
            div_start   = 1'b1;
            state_in    = ST_DIV_UP;
         end
         ST_DIV_UP: begin
            if (div_done) begin
               t_up_in   = div_q;
               div_start = 1'b1;
               div_den   = {1'b0, dn_rate};
               state_in  = ST_DIV_DN;
            end
         end
         ST_DIV_DN: begin
            if (div_done) begin
               t_dn_in   = div_q;
               div_start = 1'b1;
               div_num   = peak_num_ff;
               div_den   = 32'({1'b0, up_rate} + {1'b0, dn_rate});
               state_in  = ST_DIV_PK;
            end
         end
         ST_DIV_PK: begin
            if (div_done) begin
               t_pk_in  = div_q;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // In the triangle case the plateau window is empty.
            if (triangle) begin
               thresh_in.rise_end = t_pk_ff[VAL_W-1:0];
               thresh_in.flat_end = t_pk_ff[VAL_W-1:0];
            end else begin
               thresh_in.rise_end = t_up_ff[VAL_W-1:0];
               thresh_in.flat_end = duration - t_dn_ff[VAL_W-1:0];
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_START;
      endcase
      if (restart) begin
         state_in  = ST_START;
         div_start = 1'b0;
      end
   end

   tpg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
      peak_num_ff <= peak_num_in;
      t_up_ff     <= t_up_in;
      t_dn_ff     <= t_dn_in;
      t_pk_ff     <= t_pk_in;
      thresh_ff   <= thresh_in;
   end

   assign busy   = state_ff != ST_IDLE;
   assign thresh = thresh_ff;

endmodule

// File: src/tpg_front.sv
// Front end: classifies a time point into its phase and picks the ramp operands.
`timescale 1ns / 1ps

module tpg_front
   import tpg_pkg::*;
(
   input  logic [TIME_W-1:0] time_point,
   input  logic [VAL_W-1:0]  up_rate,
   input  logic [VAL_W-1:0]  dn_rate,
   input  logic [VAL_W-1:0]  duration,
   input  tpg_thresh_type    thresh,
   output tpg_item_type      item
);

   logic [VAL_W-1:0] t;
   logic             in_range;

   assign t = time_point[VAL_W-1:0];
   assign in_range = !time_point[TIME_W-1] && (t < duration);

   always_comb begin
      item = '0;
      priority if (!in_range) begin
         item.phase = PH_OUT;
      end else if (t < thresh.rise_end) begin
         item.phase     = PH_RISE;
         item.ramp_time = t;
         item.rate      = up_rate;
      end else if (t < thresh.flat_end) begin
         item.phase = PH_FLAT;
      end else begin
         item.phase     = PH_FALL;
         item.ramp_time = duration - t;
         item.rate      = dn_rate;
      end
   end

endmodule

// File: src/tpg_queue.sv
// Small FIFO between the classifier and the ramp multiplier.
`timescale 1ns / 1ps

module tpg_queue
   import tpg_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tpg_item_type push_item,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output tpg_item_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   tpg_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign full      = cnt_ff == CNT_W'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rd_ff];

endmodule

// File: src/tpg_back.sv
// Back end: ramp multiply, saturation and the response register.
`timescale 1ns / 1ps

module tpg_back
   import tpg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  tpg_item_type      item,
   output logic              item_pop,
   input  logic [VAL_W-1:0]  plateau,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [VAL_W-1:0]  rsp_profile_value,
   output logic [VAL_W-1:0]  rsp_slope_magnitude,
   output logic [1:0]        rsp_phase
);

   logic              v1_ff, v1_in, v2_ff, v2_in;
   logic [PROD_W-1:0] prod_ff;
   logic [VAL_W-1:0]  rate_ff;
   logic [1:0]        phase_ff;
   logic [VAL_W-1:0]  value_ff, slope_ff, ramp_sat;
   logic [1:0]        phase2_ff;
   logic              en1, en2;

   assign en2      = !v2_ff || !rsp_stall;
   assign en1      = !v1_ff || en2;
   assign item_pop = item_valid && en1;
   assign v1_in    = en1 ? item_valid : v1_ff;
   assign v2_in    = en2 ? v1_ff : v2_ff;

   // Drop the fraction bits and clamp anything above the 31-bit range.
   assign ramp_sat = (|prod_ff[PROD_W-1:VAL_W+FRAC_W]) ? {VAL_W{1'b1}}
                                                       : prod_ff[VAL_W+FRAC_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (en1) begin
         prod_ff  <= PROD_W'(item.ramp_time) * PROD_W'(item.rate);
         rate_ff  <= item.rate;
         phase_ff <= item.phase;
      end
      if (en2) begin
         value_ff  <= (phase_ff == PH_FLAT) ? plateau : ramp_sat;
         slope_ff  <= rate_ff;
         phase2_ff <= phase_ff;
      end
   end

   assign rsp_valid           = v2_ff;
   assign rsp_profile_value   = value_ff;
   assign rsp_slope_magnitude = slope_ff;
   assign rsp_phase           = phase2_ff;

endmodule

// File: src/trapezoid_profile_generator_top.sv
// Top level of the trapezoid profile generator.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | time_point
//   rsp     | out       | rsp_valid/stall    | profile_value, slope_magnitude, phase
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// One time point is accepted per cycle while req_stall is low; a transaction goes
// from request to response via classify into the queue, multiply, output register.
// After reset and after every register write the phase boundaries are rebuilt
// by the shared one-bit-per-cycle divider; req_stall is high until they are ready.
// A stalled response backs up into the queue; requests also stall when it is full.
`timescale 1ns / 1ps

module trapezoid_profile_generator_top
   import tpg_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [TIME_W-1:0] req_time_point,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [VAL_W-1:0]  rsp_profile_value,
   output logic [VAL_W-1:0]  rsp_slope_magnitude,
   output logic [1:0]        rsp_phase,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [VAL_W-1:0]  csr_wdata
);

   logic [VAL_W-1:0] rise_ff, fall_ff, plateau_ff, duration_ff;
   logic [VAL_W-1:0] up_rate, dn_rate;
   logic             setup_busy, q_full, q_not_empty, q_pop, push;
   tpg_thresh_type   thresh;
   tpg_item_type     front_item, head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff     <= VAL_W'(65536);
         fall_ff     <= VAL_W'(65536);
         plateau_ff  <= VAL_W'(65536);
         duration_ff <= VAL_W'(131072);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RISE_RATE:      rise_ff     <= csr_wdata;
            REG_FALL_RATE:      fall_ff     <= csr_wdata;
            REG_PLATEAU_LEVEL:  plateau_ff  <= csr_wdata;
            REG_TOTAL_DURATION: duration_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero rate is treated as the smallest nonzero rate.
   assign up_rate = (rise_ff == '0) ? VAL_W'(1) : rise_ff;
   assign dn_rate = (fall_ff == '0) ? VAL_W'(1) : fall_ff;

   tpg_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_we),
      .up_rate  (up_rate),
      .dn_rate  (dn_rate),
      .plateau  (plateau_ff),
      .duration (duration_ff),
      .busy     (setup_busy),
      .thresh   (thresh)
   );

   tpg_front u_front (
      .time_point (req_time_point),
      .up_rate    (up_rate),
      .dn_rate    (dn_rate),
      .duration   (duration_ff),
      .thresh     (thresh),
      .item       (front_item)
   );

   assign req_stall = q_full || setup_busy;
   assign push      = req_valid && !req_stall;

   tpg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_item)
   );

   tpg_back u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (q_not_empty),
      .item                (head_item),
      .item_pop            (q_pop),
      .plateau             (plateau_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_profile_value   (rsp_profile_value),
      .rsp_slope_magnitude (rsp_slope_magnitude),
      .rsp_phase           (rsp_phase)
   );

endmodule
